// ===== rtl/glp_pkg.sv =====
// Shared types and constants for the grid local peak finder.
package glp_pkg;

  // Configuration port layout
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Width of the reported peak coordinates
  localparam int OUT_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // Neighbor qualification and coordinates of the cell under test
  typedef struct packed {
    logic             judge;
    logic             has_above;
    logic             has_below;
    logic             has_left;
    logic             has_right;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
  } judge_ctl_t;

endpackage

// ===== rtl/glp_if.sv =====
// Handshake channel interfaces for samples, peaks and configuration writes.
interface glp_sample_if #(parameter int VALUE_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface glp_peak_if import glp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] peak_row;
  logic [OUT_W-1:0] peak_col;

  modport source (output valid, output peak_row, output peak_col, input ready);
  modport sink   (input valid, input peak_row, input peak_col, output ready);
endinterface

interface glp_cfg_if import glp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/glp_line_mem.sv =====
// Two-row line store: one write port, two registered read ports with write bypass.
module glp_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra0,
  input  logic [AW-1:0]    ra1,
  output logic [WIDTH-1:0] rd0,
  output logic [WIDTH-1:0] rd1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q0;
  logic [WIDTH-1:0] q1;
  logic [WIDTH-1:0] wd_q;
  logic             hit0;
  logic             hit1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q0   <= mem[ra0];
    q1   <= mem[ra1];
    wd_q <= wd;
  end

  // Flag reads that collide with the write on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      hit0 <= 1'b0;
      hit1 <= 1'b0;
    end else begin
      hit0 <= we && (wa == ra0);
      hit1 <= we && (wa == ra1);
    end
  end

  assign rd0 = hit0 ? wd_q : q0;
  assign rd1 = hit1 ? wd_q : q1;

endmodule

// ===== rtl/glp_scan.sv =====
// Frame position tracking, dimension registers and line store addressing.
module glp_scan import glp_pkg::*; #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int AW       = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output judge_ctl_t           ctl,
  output logic [AW-1:0]        wr_addr,
  output logic [AW-1:0]        rd_addr_cur,
  output logic [AW-1:0]        rd_addr_right
);

  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [RW-1:0]  rows_q;
  logic [RW-1:0]  rows_next;
  logic [CCW-1:0] cols_q;
  logic [CCW-1:0] cols_next;
  logic [RW-1:0]  row_pos;
  logic [RW-1:0]  row_pos_next;
  logic [AW-1:0]  col_pos;
  logic [AW-1:0]  col_pos_next;

  logic           in_frame;
  logic [RW-1:0]  r_cur;
  logic [AW-1:0]  c_cur;
  logic [CCW-1:0] c_inc;
  logic           has_right;
  logic [RW-1:0]  r_adv;
  logic [AW-1:0]  c_adv;
  logic           look_in_frame;
  logic [AW-1:0]  c_look;

  function automatic logic [RW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RW-1:0] res;
    priority if (v == '0) res = RW'(1);
    else if (int'(v) > MAX_ROWS) res = RW'(MAX_ROWS);
    else res = RW'(v);
    return res;
  endfunction

  function automatic logic [CCW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CCW-1:0] res;
    priority if (v == '0) res = CCW'(1);
    else if (int'(v) > MAX_COLS) res = CCW'(MAX_COLS);
    else res = CCW'(v);
    return res;
  endfunction

  // Dimension registers hold the clamped values
  always_comb begin
    rows_next = rows_q;
    cols_next = cols_q;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_GRID_ROWS: rows_next = clamp_rows(cfg_data);
        CFG_GRID_COLS: cols_next = clamp_cols(cfg_data);
        default:       rows_next = rows_q;
      endcase
    end
  end

  // Restart at the origin when the stored position fell outside the frame
  assign in_frame = (row_pos <= rows_q) && (CCW'(col_pos) < cols_q);
  assign r_cur    = in_frame ? row_pos : '0;
  assign c_cur    = in_frame ? col_pos : '0;

  assign c_inc     = CCW'(c_cur) + CCW'(1);
  assign has_right = c_inc < cols_q;
  assign c_adv     = has_right ? c_inc[AW-1:0] : '0;
  assign r_adv     = has_right ? r_cur : ((r_cur < rows_q) ? r_cur + RW'(1) : '0);

  assign row_pos_next = accept ? r_adv : row_pos;
  assign col_pos_next = accept ? c_adv : col_pos;

  // Look ahead: address the column the next beat will land on
  assign look_in_frame = (row_pos_next <= rows_next) && (CCW'(col_pos_next) < cols_next);
  assign c_look        = look_in_frame ? col_pos_next : '0;
  assign rd_addr_cur   = c_look;
  assign rd_addr_right = c_look + AW'(1);
  assign wr_addr       = c_cur;

  always_comb begin
    logic [31:0] row_w;
    logic [31:0] col_w;
    row_w         = 32'(r_cur) - 32'd1;
    col_w         = 32'(c_cur);
    ctl.judge     = (r_cur != '0);
    ctl.has_above = (r_cur >= RW'(2));
    ctl.has_below = (r_cur < rows_q);
    ctl.has_left  = (c_cur != '0);
    ctl.has_right = has_right;
    ctl.row       = row_w[OUT_W-1:0];
    ctl.col       = col_w[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_q  <= RW'(1);
      cols_q  <= CCW'(1);
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      rows_q  <= rows_next;
      cols_q  <= cols_next;
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

endmodule

// ===== rtl/glp_judge.sv =====
// Neighbor comparison and the result register.
module glp_judge import glp_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [VALUE_WIDTH-1:0] sample_value,
  input  judge_ctl_t                    ctl,
  input  logic [2*VALUE_WIDTH-1:0]      cell_entry,
  input  logic [2*VALUE_WIDTH-1:0]      right_entry,
  output logic                          in_ready,
  output logic                          peak_valid,
  input  logic                          peak_ready,
  output logic [OUT_W-1:0]              peak_row,
  output logic [OUT_W-1:0]              peak_col
);

  logic signed [VALUE_WIDTH-1:0] center;
  logic signed [VALUE_WIDTH-1:0] above;
  logic signed [VALUE_WIDTH-1:0] right;
  logic signed [VALUE_WIDTH-1:0] left_q;
  logic                          is_peak;

  assign center = cell_entry[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign above  = cell_entry[VALUE_WIDTH-1:0];
  assign right  = right_entry[2*VALUE_WIDTH-1:VALUE_WIDTH];

  assign is_peak = ctl.judge
                && !(ctl.has_above && (center < above))
                && !(ctl.has_below && (center < sample_value))
                && !(ctl.has_left  && (center < left_q))
                && !(ctl.has_right && (center < right));

  // Take a beat when the result slot is empty or draining
  assign in_ready = !peak_valid || peak_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (in_ready) begin
      peak_valid <= accept && is_peak;
    end
  end

  // Hold the cell just judged: it is the left neighbor of the next one
  always_ff @(posedge clk) begin
    if (accept) begin
      left_q <= center;
    end
    if (accept && is_peak) begin
      peak_row <= ctl.row;
      peak_col <= ctl.col;
    end
  end

endmodule

// ===== rtl/grid_local_peak_finder_core.sv =====
// Top level of the streaming 4-neighbor grid local peak finder.
//
// Samples arrive in row-major order, grid_rows rows of grid_cols beats, then
// one padding row of grid_cols beats whose value is ignored. When the beat at
// (r,c) is taken, cell (r-1,c) is judged: it is a peak when it is >= each of
// its up, down, left and right neighbors that lie inside the grid, and a peak
// beat carrying its row and column leaves on the peak channel. Peaks come out
// in row-major order, at most one per input beat. The block takes one sample
// every clock while the result slot is free or draining, and registers each
// result. That rate is set by the line store: one memory of MAX_COLS entries
// holding the previous and older row per column, read ahead at two addresses
// (the cell's column and the one to its right) for the next beat, and written
// once per beat. The left neighbor is the cell judged on the previous beat
// and comes from a register. Input ready follows the result register:
// a beat is taken whenever the result slot is empty or being drained. The
// line store needs no clearing after reset. Dimension registers are clamped
// on write (zero reads as one, values above the maximum saturate), and a
// position left outside a resized frame restarts at the origin.
module grid_local_peak_finder_core import glp_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLS    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  glp_cfg_if.sink       cfg,
  glp_sample_if.sink    sample,
  glp_peak_if.source    peak
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW = 2 * VALUE_WIDTH;

  logic                          accept;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  judge_ctl_t                    ctl;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr_cur;
  logic [AW-1:0]                 rd_addr_right;
  logic [EW-1:0]                 cell_entry;
  logic [EW-1:0]                 right_entry;
  logic [EW-1:0]                 wr_entry;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  assign sample_value = sample.sample_value;
  assign sample.ready = in_ready;
  assign accept       = sample.valid && in_ready;

  glp_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_idx       (cfg.index),
    .cfg_data      (cfg.data),
    .accept        (accept),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .rd_addr_cur   (rd_addr_cur),
    .rd_addr_right (rd_addr_right)
  );

  // Advance the column: the previous-row value drops to the older row and
  // the new sample becomes the previous row
  assign wr_entry = {sample_value, cell_entry[EW-1:VALUE_WIDTH]};

  glp_line_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (EW),
    .AW    (AW)
  ) u_line_mem (
    .clk (clk),
    .rst (rst),
    .we  (accept),
    .wa  (wr_addr),
    .wd  (wr_entry),
    .ra0 (rd_addr_cur),
    .ra1 (rd_addr_right),
    .rd0 (cell_entry),
    .rd1 (right_entry)
  );

  glp_judge #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_judge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample_value (sample_value),
    .ctl          (ctl),
    .cell_entry   (cell_entry),
    .right_entry  (right_entry),
    .in_ready     (in_ready),
    .peak_valid   (peak.valid),
    .peak_ready   (peak.ready),
    .peak_row     (peak.peak_row),
    .peak_col     (peak.peak_col)
  );

endmodule

// ===== sim/grid_local_peak_finder_core_tb.sv =====
// Self-checking testbench for the streaming 4-neighbor grid local peak finder.
`timescale 1ns / 100ps

module grid_local_peak_finder_core_tb import glp_pkg::*; ();

  localparam int MAX_ROWS       = 1024;
  localparam int MAX_COLS       = 1024;
  localparam int VW             = 16;
  // Quiet cycles (no beat on any channel) before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // The result register is loaded in the cycle after its input beat; leave margin.
  localparam int HOLD_OFF       = 4;
  localparam int DRAIN          = 10;
  localparam int RANDOM_ITEMS   = 750;
  // Keep a badly broken block from flooding the log.
  localparam int REPORT_CAP     = 100;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
  } peak_coord_t;

  // Tracks the frame position and both line stores, predicts which cells
  // are peaks, and holds the predicted coordinates until the block emits them.
  class peak_ledger;
    logic [CFG_W-1:0]     rows_reg;
    logic [CFG_W-1:0]     cols_reg;
    logic signed [VW-1:0] prev_line [MAX_COLS];
    logic signed [VW-1:0] old_line  [MAX_COLS];
    int unsigned          row_pos;
    int unsigned          col_pos;
    peak_coord_t          pending_peaks [$];
    int                   mismatches;

    function void clear();
      rows_reg = 1;
      cols_reg = 1;
      foreach (prev_line[i]) begin
        prev_line[i] = '0;
        old_line[i]  = '0;
      end
      row_pos = 0;
      col_pos = 0;
      pending_peaks.delete();
      mismatches = 0;
    endfunction

    // Zero counts as one, anything above the maximum saturates.
    function int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int unsigned eff_rows();
      return eff_dim(rows_reg, MAX_ROWS);
    endfunction

    function int unsigned eff_cols();
      return eff_dim(cols_reg, MAX_COLS);
    endfunction

    function int pending();
      return pending_peaks.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_GRID_ROWS: rows_reg = d;
        CFG_GRID_COLS: cols_reg = d;
        default: ;
      endcase
    endfunction

    // Judge cell (r-1,c) when the beat at (r,c) arrives.
    function void note_sample(logic signed [VW-1:0] s);
      int unsigned          nr;
      int unsigned          nc;
      int unsigned          r;
      int unsigned          c;
      logic signed [VW-1:0] center;
      logic                 keep;
      peak_coord_t          found;
      nr = eff_rows();
      nc = eff_cols();
      // A resize can leave the position outside the frame: restart it.
      if (row_pos > nr || col_pos >= nc) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (r >= 1) begin
        center = prev_line[c];
        keep = 1'b1;
        if (r >= 2 && center < old_line[c]) keep = 1'b0;
        // In the padding row there is no neighbor below.
        if (r < nr && center < s) keep = 1'b0;
        if (c >= 1 && center < old_line[c-1]) keep = 1'b0;
        if (c + 1 < nc && center < prev_line[c+1]) keep = 1'b0;
        if (keep) begin
          found.row = OUT_W'(r - 1);
          found.col = OUT_W'(c);
          pending_peaks.push_back(found);
        end
      end
      old_line[c]  = prev_line[c];
      prev_line[c] = s;
      if (c + 1 < nc) begin
        col_pos = c + 1;
      end else begin
        col_pos = 0;
        row_pos = (r < nr) ? r + 1 : 0;
      end
    endfunction

    function void flag(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_peak(logic [OUT_W-1:0] row, logic [OUT_W-1:0] col);
      peak_coord_t want;
      if (pending_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("peak beat at row %0d col %0d with no peak pending", row, col);
        return;
      end
      want = pending_peaks.pop_front();
      if (row !== want.row) flag("peak_row", want.row, row);
      if (col !== want.col) flag("peak_col", want.col, col);
    endfunction
  endclass

  logic clk;
  logic rst;

  glp_sample_if #(.VALUE_WIDTH(VW)) sample_ch ();
  glp_peak_if                       peak_ch ();
  glp_cfg_if                        cfg_ch ();

  grid_local_peak_finder_core #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VW)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .peak   (peak_ch)
  );

  peak_ledger ledger;

  int burst_left   = 0;
  int ready_mode   = 0;
  int ready_left   = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Peak receiver: switch between free flow, coin-flip stalls and heavy
  // back-pressure, each mode held for a random stretch.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(4, 60);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       peak_ch.ready <= 1'b1;
      1:       peak_ch.ready <= 1'($urandom_range(0, 1));
      default: peak_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Observe every channel at the edge where a beat moves. Signals are read
  // before this edge's updates land, so no ordering race within the step.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        ledger.note_sample(sample_ch.sample_value);
      if (peak_ch.valid && peak_ch.ready)
        ledger.check_peak(peak_ch.peak_row, peak_ch.peak_col);
      if (cfg_ch.valid && cfg_ch.ready)
        ledger.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (peak_ch.valid && peak_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[grid_local_peak_finder_core] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [VW-1:0] pick_value(int vmode);
    case (vmode)
      // Narrow range around zero: plenty of ties and plateaus.
      2: return VW'(int'($urandom_range(0, 3)) - 2);
      // Only the corners of the value range.
      3: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(VW-1){1'b0}}};
          1:       return {1'b0, {(VW-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return VW'($urandom);
    endcase
  endfunction

  // Mostly small dimensions, now and then zero or a value at/above the limit.
  function automatic logic [CFG_W-1:0] pick_dim(int small_max);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'($urandom_range(1024, 2047));
      default: return CFG_W'($urandom_range(1, small_max));
    endcase
  endfunction

  // Send one sample; open a new burst (after a random gap) when one runs out.
  task automatic send_sample(logic signed [VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= v;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted peak, then give the result
  // register time to empty before touching the registers.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // One register write; the trailing edge lets the observer log it.
  task automatic write_dim(cfg_reg_t idx, logic [CFG_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [VW-1:0] mixed_grid [12];
    int                   random_items;
    int                   frame_len;
    int                   n;
    int                   pick;
    int                   vmode;

    ledger = new();
    ledger.clear();
    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample_value <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_GRID_ROWS;
    cfg_ch.data            <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // 3x3 grid of value extremes plus a tie, then the padding row.
    mixed_grid = '{16'sh8000, 16'sh7FFF, 16'sh0000,
                   16'sh0005, 16'sh0005, 16'shFFFF,
                   16'sh7FFF, 16'sh8000, 16'sh7FFF,
                   16'sh1234, 16'shEDCB, 16'sh0000};

    // Reset dimensions are 1x1: the lone cell is a peak, judged on the
    // padding beat whose value must not matter.
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);

    settle();
    write_dim(CFG_GRID_ROWS, 3);
    write_dim(CFG_GRID_COLS, 3);
    foreach (mixed_grid[i]) send_sample(mixed_grid[i]);

    // Flat plateau: every cell ties with its neighbors, so all are peaks.
    settle();
    write_dim(CFG_GRID_ROWS, 2);
    write_dim(CFG_GRID_COLS, 4);
    repeat (12) send_sample(-16'sd7);

    // Widest frame: zero rows counts as one, columns saturate at the limit.
    // This also fills every line store entry, so later mid-frame resizes
    // never read a column that was not written.
    settle();
    write_dim(CFG_GRID_ROWS, 0);
    write_dim(CFG_GRID_COLS, 2047);
    repeat (2 * MAX_COLS) send_sample(pick_value(0));

    // Tallest frame: rows saturate, zero columns counts as one.
    settle();
    write_dim(CFG_GRID_ROWS, 2047);
    write_dim(CFG_GRID_COLS, 0);
    repeat (MAX_ROWS + 1) send_sample(pick_value(0));

    // Random phases: small frames, usually whole ones, sometimes cut short
    // so the next resize lands mid-frame.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 3);
      if (pick != 1) write_dim(CFG_GRID_ROWS, pick_dim(6));
      if (pick != 0) write_dim(CFG_GRID_COLS, pick_dim(10));
      frame_len = (ledger.eff_rows() + 1) * ledger.eff_cols();
      // Huge frames only ever get a short partial run.
      if (frame_len > 200 || $urandom_range(0, 4) == 0)
        n = $urandom_range(1, (frame_len - 1 < 40) ? frame_len - 1 : 40);
      else
        n = frame_len * $urandom_range(1, 3);
      vmode = $urandom_range(0, 3);
      repeat (n) send_sample(pick_value(vmode));
      random_items += n;
    end

    settle();
    repeat (DRAIN) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("[grid_local_peak_finder_core] OK");
    end else begin
      $display("[grid_local_peak_finder_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/glp_pkg.sv
rtl/glp_if.sv
rtl/glp_line_mem.sv
rtl/glp_scan.sv
rtl/glp_judge.sv
rtl/grid_local_peak_finder_core.sv
sim/grid_local_peak_finder_core_tb.sv
